// ===== rtl/lgrs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lgrs_pkg;

  localparam int MAX_WIDTH = 64;
  localparam int ROW_W     = 64;
  localparam int GW_W      = 7;
  localparam int CNT_W     = 4;
  localparam logic [GW_W-1:0] GW_RESET = GW_W'(MAX_WIDTH);
  localparam logic [CNT_W-1:0] CNT_BORN = CNT_W'(3);
  localparam logic [CNT_W-1:0] CNT_KEEP = CNT_W'(2);

  typedef struct packed {
    logic up;
    logic mid;
    logic down;
  } lgrs_col_t;

  typedef struct packed {
    logic load;
    logic keep;
    logic clear;
  } lgrs_ctrl_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic             last;
  } lgrs_res_t;

endpackage

`default_nettype wire

// ===== rtl/lgrs_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lgrs_cell (
  input  wire logic                clk,
  input  wire lgrs_pkg::lgrs_ctrl_t ctrl,
  input  wire logic                en,
  input  wire logic                down_bit,
  input  wire lgrs_pkg::lgrs_col_t left,
  input  wire lgrs_pkg::lgrs_col_t right,
  output lgrs_pkg::lgrs_col_t      own,
  output logic                     next_bit
);
  import lgrs_pkg::*;

  logic above;
  logic middle;
  logic [CNT_W-1:0] cnt;

  assign own.up   = above & en;
  assign own.mid  = middle & en;
  assign own.down = down_bit & en;

  always_comb begin
    cnt = CNT_W'(left.up) + CNT_W'(own.up) + CNT_W'(right.up)
        + CNT_W'(left.mid) + CNT_W'(right.mid)
        + CNT_W'(left.down) + CNT_W'(own.down) + CNT_W'(right.down);
    next_bit = en & ((cnt == CNT_BORN) | (own.mid & (cnt == CNT_KEEP)));
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      above  <= 1'b0;
      middle <= 1'b0;
    end else if (ctrl.load) begin
      above  <= ctrl.keep & middle;
      middle <= down_bit;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lgrs_out_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lgrs_out_fifo (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                wr_en,
  input  wire lgrs_pkg::lgrs_res_t wr_data,
  output logic                     space,
  output logic                     rd_valid,
  output lgrs_pkg::lgrs_res_t      rd_data,
  input  wire logic                rd_ready
);
  import lgrs_pkg::*;

  lgrs_res_t   slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        do_wr;
  logic        do_rd;

  assign space    = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = slots[rd_ptr];
  assign do_wr    = wr_en & space;
  assign do_rd    = rd_valid & rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_rd) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(do_wr) - 2'(do_rd);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/life_generation_row_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One generation of Life (B3/S23) over a grid of up to 64 columns, row by row.
// Input stream s_*: one current-generation row per request, top row first;
// s_tlast marks the bottom row of the grid. Output stream m_*: next-generation
// rows in order; m_tlast marks the bottom row of the new generation.
// Row r of input yields row r-1 of output, which enters the output queue when row
// r is taken; the first row of a grid yields nothing unless it is also the bottom row.
// A bottom row adds one result, formed while flushing with s_tready low.
// Otherwise one row is taken per cycle while the output queue has space.
// Each column is one cell holding its bits of the two held rows and trading
// them with its neighbors; all columns count neighbors in parallel.
// cfg_we/cfg_wdata set the grid width; columns at or above it are dead and
// read as zero. Write it only between grids.
// A two-entry output queue decouples the sides: while m_tready is low the
// block keeps taking rows until the queue is full, then drops s_tready.
// Reset empties the queue, clears the held rows and sets the width to 64.
module life_generation_row_step (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [lgrs_pkg::GW_W-1:0]     cfg_wdata,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [lgrs_pkg::ROW_W-1:0]    s_tdata,   // row_cells
  input  wire logic                          s_tlast,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [lgrs_pkg::ROW_W-1:0]         m_tdata,   // next_row
  output logic                               m_tlast
);
  import lgrs_pkg::*;

  logic [GW_W-1:0]  grid_width;
  logic             mid_valid;
  logic             flush;
  logic             space;
  logic             acc;
  logic             flush_go;
  lgrs_ctrl_t       ctrl;
  lgrs_res_t        res;
  lgrs_res_t        rd_data;
  logic [ROW_W-1:0] en;
  logic [ROW_W-1:0] down_row;
  logic [ROW_W-1:0] next_row;
  lgrs_col_t        cols [ROW_W];

  assign s_tready = space & ~flush;
  assign acc      = s_tvalid & s_tready;
  assign flush_go = flush & space;

  assign ctrl.load  = acc;
  assign ctrl.keep  = mid_valid;
  assign ctrl.clear = rst | flush_go;

  assign down_row = flush ? '0 : s_tdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width <= GW_RESET;
    end else if (cfg_we) begin
      grid_width <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
      flush     <= 1'b0;
    end else if (flush_go) begin
      mid_valid <= 1'b0;
      flush     <= 1'b0;
    end else if (acc) begin
      mid_valid <= 1'b1;
      flush     <= s_tlast;
    end
  end

  for (genvar i = 0; i < ROW_W; i++) begin : g_col
    lgrs_col_t left;
    lgrs_col_t right;

    assign en[i] = GW_W'(i) < grid_width;

    if (i == 0) begin : g_left_edge
      assign left = '0;
    end else begin : g_left
      assign left = cols[i-1];
    end

    if (i == ROW_W - 1) begin : g_right_edge
      assign right = '0;
    end else begin : g_right
      assign right = cols[i+1];
    end

    lgrs_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .en       (en[i]),
      .down_bit (down_row[i]),
      .left     (left),
      .right    (right),
      .own      (cols[i]),
      .next_bit (next_row[i])
    );
  end

  assign res.row  = next_row;
  assign res.last = flush;

  lgrs_out_fifo u_out_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    ((acc & mid_valid) | flush_go),
    .wr_data  (res),
    .space    (space),
    .rd_valid (m_tvalid),
    .rd_data  (rd_data),
    .rd_ready (m_tready)
  );

  assign m_tdata = rd_data.row;
  assign m_tlast = rd_data.last;

endmodule

`default_nettype wire
